@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the piecewise-linear schedule RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, quiet while rst_n is low
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet while rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pls_pkg.sv @@
// ---------------------------------------------------------------------------
// pls_pkg
// Types and constants shared by the piecewise-linear schedule modules.
// ---------------------------------------------------------------------------
package pls_pkg;

  localparam int unsigned ValW     = 32;  // Q16.16 word
  localparam int unsigned IdxW     = 4;   // point_index / segment field
  localparam int unsigned CntW     = 5;   // point_count register
  localparam int unsigned DivSteps = 33;  // quotient bits of the divider
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    REGION_INTERIOR = 3'd0,
    REGION_FIRST    = 3'd1,
    REGION_LAST     = 3'd2,
    REGION_SINGLE   = 3'd3,
    REGION_EMPTY    = 3'd4
  } region_t;

  typedef enum logic {
    CFG_POINT_COUNT = 1'b0,
    CFG_CONSTANT    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ADDR_FIRST,
    ADDR_LAST,
    ADDR_SCAN,
    ADDR_NEXT
  } addr_sel_t;

  typedef enum logic [1:0] {
    RES_CONST,
    RES_DATA,
    RES_INTERP
  } res_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic      wr_point;
    logic      accept;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      keep_prev;
    logic      keep_cur;
    logic      idx_first;
    logic      idx_inc;
    logic      set_res;
    res_src_t  res_src;
    region_t   res_region;
    logic      prep;
    logic      mul;
    logic      div_step;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic t_ge_q;    // time on the read port is at or above the query
    logic q_ge_t;    // query is at or above the time on the read port
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/pls_ram.sv @@
// ---------------------------------------------------------------------------
// pls_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module pls_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/pls_ctrl.sv @@
// ---------------------------------------------------------------------------
// pls_ctrl
// Sequencer: table search, multiply, serial divide and result hand-off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pls_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_command,
  output logic            in_ready,
  input  pls_pkg::stat_t  stat,
  output pls_pkg::cmd_t   cmd
);

  pls_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pls_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      pls_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == pls_pkg::CMD_EVAL) begin
            if (stat.n_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_src    = pls_pkg::RES_CONST;
              cmd.res_region = pls_pkg::REGION_EMPTY;
              state_nxt      = pls_pkg::ST_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = pls_pkg::ADDR_FIRST;
              state_nxt  = pls_pkg::ST_FIRST;
            end
          end else begin
            cmd.wr_point = 1'b1;
          end
        end
      end
      pls_pkg::ST_FIRST: begin
        cmd.keep_prev = 1'b1;
        cmd.idx_first = 1'b1;
        priority if (stat.n_one) begin
          cmd.set_res    = 1'b1;
          cmd.res_src    = pls_pkg::RES_DATA;
          cmd.res_region = pls_pkg::REGION_SINGLE;
          state_nxt      = pls_pkg::ST_DONE;
        end else if (stat.t_ge_q) begin
          cmd.set_res    = 1'b1;
          cmd.res_src    = pls_pkg::RES_DATA;
          cmd.res_region = pls_pkg::REGION_FIRST;
          state_nxt      = pls_pkg::ST_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pls_pkg::ADDR_LAST;
          state_nxt  = pls_pkg::ST_LAST;
        end
      end
      pls_pkg::ST_LAST: begin
        if (stat.q_ge_t) begin
          cmd.set_res    = 1'b1;
          cmd.res_src    = pls_pkg::RES_DATA;
          cmd.res_region = pls_pkg::REGION_LAST;
          state_nxt      = pls_pkg::ST_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pls_pkg::ADDR_SCAN;
          state_nxt  = pls_pkg::ST_SCAN;
        end
      end
      pls_pkg::ST_SCAN: begin
        if (stat.t_ge_q) begin
          cmd.keep_cur = 1'b1;
          state_nxt    = pls_pkg::ST_PREP;
        end else begin
          cmd.keep_prev = 1'b1;
          cmd.idx_inc   = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = pls_pkg::ADDR_NEXT;
        end
      end
      pls_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = pls_pkg::ST_MUL;
      end
      pls_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = pls_pkg::ST_DIV;
      end
      pls_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = pls_pkg::ST_FIX;
        end
      end
      pls_pkg::ST_FIX: begin
        cmd.set_res    = 1'b1;
        cmd.res_src    = pls_pkg::RES_INTERP;
        cmd.res_region = pls_pkg::REGION_INTERIOR;
        state_nxt      = pls_pkg::ST_DONE;
      end
      pls_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = pls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pls_pkg::ST_IDLE;
      end
    endcase
  end

  // an accepted evaluate must hold off the next beat
  `ASSERT_NEXT(a_eval_holds_input, in_valid && in_ready && in_command == pls_pkg::CMD_EVAL, !in_ready, "input taken while an evaluate is in flight")

  // the divider always finishes into the fix-up step
  `ASSERT_NEXT(a_div_exit, state_r == pls_pkg::ST_DIV && stat.div_last, state_r == pls_pkg::ST_FIX, "divider did not hand over to fix-up")

endmodule

@@ rtl/pls_dp.sv @@
// ---------------------------------------------------------------------------
// pls_dp
// Datapath: breakpoint RAM, compares, multiplier, restoring divider, output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pls_dp #(
  parameter int unsigned POINTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pls_pkg::cmd_t               cmd,
  output pls_pkg::stat_t              stat,
  input  logic [pls_pkg::IdxW-1:0]    point_index,
  input  logic [pls_pkg::ValW-1:0]    point_time,
  input  logic [pls_pkg::ValW-1:0]    point_value,
  input  logic [pls_pkg::ValW-1:0]    query_time,
  input  logic [pls_pkg::CntW-1:0]    point_count,
  input  logic [pls_pkg::ValW-1:0]    constant_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pls_pkg::ValW-1:0]    out_value,
  output logic [2:0]                  out_region,
  output logic [pls_pkg::IdxW-1:0]    out_segment
);

  localparam int unsigned AW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned NW = $clog2(POINTS + 1);
  localparam int unsigned VW = pls_pkg::ValW;
  localparam int unsigned WW = VW + 1;  // widened difference

  logic [NW-1:0]       n;
  logic [AW-1:0]       rd_addr;
  logic [2*VW-1:0]     ram_rdata;
  logic signed [VW-1:0] ram_t, ram_v;
  logic                ram_we;

  logic signed [VW-1:0] q_r, prev_t_r, prev_v_r, cur_t_r, cur_v_r;
  logic [AW-1:0]        idx_r;
  logic [WW-1:0]        dt_r, span_r, mag_r;
  logic                 neg_r;
  logic [WW-1:0]        rem_r, lo_r, quo_r;
  logic [pls_pkg::DivCntW-1:0] div_cnt_r;

  logic [VW-1:0]        res_value_r;
  pls_pkg::region_t     res_region_r;
  logic [pls_pkg::IdxW-1:0] res_seg_r;

  logic                 out_valid_r;
  logic [VW-1:0]        out_value_r;
  pls_pkg::region_t     out_region_r;
  logic [pls_pkg::IdxW-1:0] out_seg_r;

  logic [WW:0]          trial;
  logic                 take;
  logic [WW-1:0]        rem_nxt;
  logic [2*WW-1:0]      prod;
  logic                 v_lt;
  logic [VW-1:0]        step, interp;

  // count above the table depth behaves as a full table
  always_comb begin
    if (32'(point_count) > 32'(POINTS)) begin
      n = NW'(POINTS);
    end else begin
      n = NW'(point_count);
    end
  end

  assign ram_we = cmd.wr_point && (32'(point_index) < 32'(POINTS));

  always_comb begin
    unique case (cmd.rd_sel)
      pls_pkg::ADDR_FIRST: rd_addr = '0;
      pls_pkg::ADDR_LAST:  rd_addr = AW'(n - NW'(1));
      pls_pkg::ADDR_SCAN:  rd_addr = idx_r;
      pls_pkg::ADDR_NEXT:  rd_addr = idx_r + AW'(1);
      default:             rd_addr = '0;
    endcase
  end

  pls_ram #(
    .WIDTH (2 * VW),
    .DEPTH (POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(point_index)),
    .wdata ({point_value, point_time}),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign ram_t = $signed(ram_rdata[VW-1:0]);
  assign ram_v = $signed(ram_rdata[2*VW-1:VW]);

  // divider step: shift one dividend bit into the partial remainder
  assign trial   = {rem_r, lo_r[WW-1]};
  assign take    = trial >= {1'b0, span_r};
  assign rem_nxt = take ? WW'(trial - {1'b0, span_r}) : trial[WW-1:0];

  assign prod   = mag_r * dt_r;
  assign v_lt   = cur_v_r < prev_v_r;
  assign step   = neg_r ? (~quo_r[VW-1:0] + VW'(1)) : quo_r[VW-1:0];
  assign interp = prev_v_r + step;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_r <= $signed(query_time);
    end
    if (cmd.keep_prev) begin
      prev_t_r <= ram_t;
      prev_v_r <= ram_v;
    end
    if (cmd.keep_cur) begin
      cur_t_r <= ram_t;
      cur_v_r <= ram_v;
    end
    if (cmd.idx_first) begin
      idx_r <= AW'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.prep) begin
      dt_r   <= {q_r[VW-1], q_r} - {prev_t_r[VW-1], prev_t_r};
      span_r <= {cur_t_r[VW-1], cur_t_r} - {prev_t_r[VW-1], prev_t_r};
      neg_r  <= v_lt;
      mag_r  <= v_lt ? ({prev_v_r[VW-1], prev_v_r} - {cur_v_r[VW-1], cur_v_r})
                     : ({cur_v_r[VW-1], cur_v_r} - {prev_v_r[VW-1], prev_v_r});
    end
    // product's upper half is already below the span, so only the
    // lower half needs shifting through
    if (cmd.mul) begin
      rem_r     <= prod[2*WW-1:WW];
      lo_r      <= prod[WW-1:0];
      quo_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      lo_r      <= {lo_r[WW-2:0], 1'b0};
      quo_r     <= {quo_r[WW-2:0], take};
      div_cnt_r <= div_cnt_r + pls_pkg::DivCntW'(1);
    end
    if (cmd.set_res) begin
      res_region_r <= cmd.res_region;
      unique case (cmd.res_src)
        pls_pkg::RES_CONST: begin
          res_value_r <= constant_value;
          res_seg_r   <= '0;
        end
        pls_pkg::RES_DATA: begin
          res_value_r <= ram_v;
          res_seg_r   <= '0;
        end
        pls_pkg::RES_INTERP: begin
          res_value_r <= interp;
          res_seg_r   <= pls_pkg::IdxW'(idx_r);
        end
        default: begin
          res_value_r <= constant_value;
          res_seg_r   <= '0;
        end
      endcase
    end
    if (cmd.load_out) begin
      out_value_r  <= res_value_r;
      out_region_r <= res_region_r;
      out_seg_r    <= res_seg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.n_zero   = (n == '0);
    stat.n_one    = (n == NW'(1));
    stat.t_ge_q   = ram_t >= q_r;
    stat.q_ge_t   = q_r >= ram_t;
    stat.div_last = (div_cnt_r == pls_pkg::DivCntW'(pls_pkg::DivSteps - 1));
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_region  = out_region_r;
  assign out_segment = out_seg_r;

  // partial remainder must stay below the divisor through every step
  `ASSERT_IMPLIES(a_rem_below_span, cmd.div_step, rem_r < span_r, "divider remainder not below span")

  // a finished result never overwrites one still waiting
  `ASSERT_IMPLIES(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready, "result register overwritten")

endmodule

@@ rtl/piecewise_linear_schedule.sv @@
// ---------------------------------------------------------------------------
// piecewise_linear_schedule
// Breakpoint table with clamped linear interpolation, Q16.16 fixed point.
// ---------------------------------------------------------------------------
//
//   channel  | dir | handshake              | contents
//   ---------+-----+------------------------+-----------------------------------
//   in_      | in  | in_tvalid / in_tready  | tuser: command; tdata: index,
//            |     |                        | point time, point value, query
//   out_     | out | out_tvalid / out_tready| tuser: region; tdata: value, segment
//   cfg_     | in  | APB, pready tied high  | 0x0 point_count, 0x4 constant_value
//
// A breakpoint write is taken in the idle state. An evaluate occupies the
// sequencer until its result is loaded into the output register, whether for
// an empty table, a single point, a query clamped to the first or last point,
// or an interior point; that one reads the breakpoints one at a time on the
// single RAM read port, then runs a difference stage, a 33x33 multiply and a 33-step restoring divide.
// Results wait in an output register, so a stalled out_ requiring its beat
// only holds the sequencer once the next result is ready to load.
// Reset is synchronous, active low; the breakpoint RAM is not cleared.
// ---------------------------------------------------------------------------
module piecewise_linear_schedule #(
  parameter int unsigned POINTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  // input beat
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [0:0]    in_tuser,    // [0] command
  input  logic [103:0]  in_tdata,    // [3:0] point_index, [35:4] point_time,
                                     // [67:36] point_value, [99:68] query_time
  // result beat
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [2:0]    out_tuser,   // [2:0] region
  output logic [39:0]   out_tdata,   // [31:0] value, [35:32] segment
  // configuration
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  pls_pkg::cmd_t  cmd;
  pls_pkg::stat_t stat;

  logic [pls_pkg::CntW-1:0] count_r;
  logic [pls_pkg::ValW-1:0] const_r;
  logic                     cfg_wr;
  pls_pkg::cfg_reg_t        cfg_sel;

  logic [pls_pkg::ValW-1:0] res_value;
  logic [pls_pkg::IdxW-1:0] res_segment;

  // register file: word-addressed, bit 2 picks the register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = pls_pkg::cfg_reg_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      const_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        pls_pkg::CFG_POINT_COUNT: count_r <= cfg_pwdata[pls_pkg::CntW-1:0];
        pls_pkg::CFG_CONSTANT:    const_r <= cfg_pwdata;
        default:                  count_r <= count_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      pls_pkg::CFG_POINT_COUNT: cfg_prdata = 32'(count_r);
      pls_pkg::CFG_CONSTANT:    cfg_prdata = const_r;
      default:                  cfg_prdata = '0;
    endcase
  end

  pls_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_command (in_tuser[0]),
    .in_ready   (in_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pls_dp #(
    .POINTS (POINTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .point_index    (in_tdata[3:0]),
    .point_time     (in_tdata[35:4]),
    .point_value    (in_tdata[67:36]),
    .query_time     (in_tdata[99:68]),
    .point_count    (count_r),
    .constant_value (const_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_value      (res_value),
    .out_region     (out_tuser),
    .out_segment    (res_segment)
  );

  assign out_tdata = {4'b0000, res_segment, res_value};

endmodule
